@@ hw/rtl/icy_pkg.sv @@
// Shared constants, types and the title key table for the ICY metadata deframer.
`timescale 1ns / 1ps

package icy_pkg;

   // Field widths
   localparam int INTERVAL_W = 31;
   localparam int POS_W      = 12;
   localparam int KEY_LEN    = 13;
   localparam int KEY_IDX_W  = $clog2(KEY_LEN + 1);

   // Queue between the framer and the parser
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Byte class codes
   localparam logic [1:0] CLASS_AUDIO  = 2'd0;
   localparam logic [1:0] CLASS_LENGTH = 2'd1;
   localparam logic [1:0] CLASS_META   = 2'd2;

   // Characters the matchers look for
   localparam logic [7:0] CHAR_QUOTE = 8'h27;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;

   // "StreamTitle='"
   localparam logic [7:0] TITLE_KEY [KEY_LEN] = '{
      8'h53, 8'h74, 8'h72, 8'h65, 8'h61, 8'h6D, 8'h54,
      8'h69, 8'h74, 8'h6C, 8'h65, 8'h3D, 8'h27
   };

   // Framing phase
   typedef enum logic [2:0] {
      PHASE_AUDIO  = 3'b001,
      PHASE_LENGTH = 3'b010,
      PHASE_META   = 3'b100
   } phase_type;

   // StreamTitle value search
   typedef enum logic [2:0] {
      VS_KEY   = 3'b001,
      VS_VALUE = 3'b010,
      VS_DONE  = 3'b100
   } value_state_type;

   // One classified byte on its way to the parser
   typedef struct packed {
      logic [1:0]       byte_class;
      logic [7:0]       byte_value;
      logic [POS_W-1:0] position;
      logic             last;
   } icy_entry_type;

endpackage

@@ hw/rtl/icy_req_if.sv @@
// Input channel: body bytes and restart commands.
`timescale 1ns / 1ps

interface icy_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;

   modport source (output valid, kind, data_byte, input ready);
   modport sink   (input valid, kind, data_byte, output ready);
endinterface

@@ hw/rtl/icy_rsp_if.sv @@
// Result channel: classified bytes and block-end title report.
`timescale 1ns / 1ps

interface icy_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  byte_class;
   logic [7:0]  byte_value;
   logic        block_end;
   logic        title_found;
   logic [11:0] title_offset;
   logic [11:0] title_length;
   logic        artist_split_found;
   logic [11:0] split_offset;

   modport source (output valid, byte_class, byte_value, block_end, title_found,
                   title_offset, title_length, artist_split_found, split_offset,
                   input ready);
   modport sink   (input valid, byte_class, byte_value, block_end, title_found,
                   title_offset, title_length, artist_split_found, split_offset,
                   output ready);
endinterface

@@ hw/rtl/icy_framer.sv @@
// Front end: interval register, audio/length/metadata framing and block position.
`timescale 1ns / 1ps

module icy_framer import icy_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [INTERVAL_W-1:0] csr_write_data,
   icy_req_if.sink               req,
   input  logic                  queue_full,
   output logic                  push,
   output icy_entry_type         entry
);

   logic [INTERVAL_W-1:0] interval_ff;
   phase_type             phase_ff, phase_in, phase_eff;
   logic [INTERVAL_W-1:0] audio_left_ff, audio_left_in;
   logic [POS_W-1:0]      meta_left_ff, meta_left_in;
   logic [POS_W-1:0]      position_ff, position_in;
   logic                  accept;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;

   // An exhausted audio count with framing on turns the next byte into a length byte
   assign phase_eff = (phase_ff == PHASE_AUDIO && interval_ff != '0 && audio_left_ff == '0)
                      ? PHASE_LENGTH : phase_ff;

   // Framing step for one transfer
   always_comb begin
      phase_in          = phase_ff;
      audio_left_in     = audio_left_ff;
      meta_left_in      = meta_left_ff;
      position_in       = position_ff;
      push              = 1'b0;
      entry.byte_class  = CLASS_AUDIO;
      entry.byte_value  = req.data_byte;
      entry.position    = position_ff;
      entry.last        = 1'b0;

      if (accept) begin
         if (req.kind) begin
            phase_in      = PHASE_AUDIO;
            audio_left_in = interval_ff;
            meta_left_in  = '0;
            position_in   = '0;
         end else begin
            push = 1'b1;
            unique case (phase_eff)
               PHASE_AUDIO: begin
                  entry.byte_class = CLASS_AUDIO;
                  if (interval_ff != '0) begin
                     audio_left_in = audio_left_ff - 1'b1;
                     if (audio_left_in == '0) begin
                        phase_in = PHASE_LENGTH;
                     end
                  end
               end
               PHASE_LENGTH: begin
                  entry.byte_class = CLASS_LENGTH;
                  // length counts 16-byte units
                  meta_left_in     = {req.data_byte, 4'h0};
                  position_in      = '0;
                  if (req.data_byte == 8'h00) begin
                     phase_in      = PHASE_AUDIO;
                     audio_left_in = interval_ff;
                  end else begin
                     phase_in = PHASE_META;
                  end
               end
               PHASE_META: begin
                  entry.byte_class = CLASS_META;
                  position_in      = position_ff + 1'b1;
                  meta_left_in     = meta_left_ff - 1'b1;
                  if (meta_left_in == '0) begin
                     entry.last    = 1'b1;
                     phase_in      = PHASE_AUDIO;
                     audio_left_in = interval_ff;
                  end
               end
               default: begin
                  phase_in = PHASE_AUDIO;
               end
            endcase
         end
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff   <= '0;
         phase_ff      <= PHASE_AUDIO;
         audio_left_ff <= '0;
         meta_left_ff  <= '0;
         position_ff   <= '0;
      end else begin
         if (csr_write_enable) begin
            interval_ff <= csr_write_data;
         end
         phase_ff      <= phase_in;
         audio_left_ff <= audio_left_in;
         meta_left_ff  <= meta_left_in;
         position_ff   <= position_in;
      end
   end

endmodule

@@ hw/rtl/icy_queue.sv @@
// Short queue of classified bytes between the framer and the parser.
`timescale 1ns / 1ps

module icy_queue import icy_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  icy_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output logic          empty,
   output icy_entry_type pop_entry
);

   icy_entry_type          slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = slots_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // The framer must hold off when full, the parser when empty
   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue written while full");
   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("queue read while empty");

endmodule

@@ hw/rtl/icy_parser.sv @@
// Back end: StreamTitle and separator matchers, block-end report, output register.
`timescale 1ns / 1ps

module icy_parser import icy_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          empty,
   input  icy_entry_type entry,
   output logic          pop,
   icy_rsp_if.source     rsp
);

   // Matcher state
   logic [KEY_IDX_W-1:0] key_idx_ff, key_idx_in;
   value_state_type      vstate_ff, vstate_in;
   logic                 quote_ff, quote_in;
   logic [POS_W-1:0]     vstart_ff, vstart_in;
   logic [POS_W-1:0]     vend_ff, vend_in;
   logic [1:0]           sep_idx_ff, sep_idx_in;
   logic                 sep_seen_ff, sep_seen_in;
   logic [POS_W-1:0]     sep_pos_ff, sep_pos_in;

   // Output register
   logic                 rsp_valid_ff;
   logic [1:0]           class_ff;
   logic [7:0]           value_ff;
   logic                 block_end_ff, block_end_in;
   logic                 title_found_ff, title_found_in;
   logic [POS_W-1:0]     title_offset_ff, title_offset_in;
   logic [POS_W-1:0]     title_length_ff, title_length_in;
   logic                 split_found_ff, split_found_in;
   logic [POS_W-1:0]     split_offset_ff, split_offset_in;

   logic                 take;
   logic [KEY_IDX_W-1:0] key_cur, key_next;
   logic [7:0]           b;

   assign b    = entry.byte_value;
   assign take = !empty && (!rsp_valid_ff || rsp.ready);
   assign pop  = take;

   // Key match step, restarting on the first key character
   assign key_cur  = (key_idx_ff >= KEY_IDX_W'(KEY_LEN)) ? '0 : key_idx_ff;
   assign key_next = (b == TITLE_KEY[key_cur]) ? key_cur + 1'b1 :
                     (b == TITLE_KEY[0])       ? KEY_IDX_W'(1) : '0;

   // Matcher update and block-end report
   always_comb begin
      key_idx_in      = key_idx_ff;
      vstate_in       = vstate_ff;
      quote_in        = quote_ff;
      vstart_in       = vstart_ff;
      vend_in         = vend_ff;
      sep_idx_in      = sep_idx_ff;
      sep_seen_in     = sep_seen_ff;
      sep_pos_in      = sep_pos_ff;
      block_end_in    = 1'b0;
      title_found_in  = 1'b0;
      title_offset_in = '0;
      title_length_in = '0;
      split_found_in  = 1'b0;
      split_offset_in = '0;

      if (take && entry.byte_class == CLASS_META) begin
         unique case (vstate_ff)
            VS_KEY: begin
               if (key_next == KEY_IDX_W'(KEY_LEN)) begin
                  key_idx_in  = '0;
                  vstate_in   = VS_VALUE;
                  vstart_in   = entry.position + 1'b1;
                  quote_in    = 1'b0;
                  sep_idx_in  = '0;
                  sep_seen_in = 1'b0;
               end else begin
                  key_idx_in = key_next;
               end
            end
            VS_VALUE: begin
               if (quote_ff && b == CHAR_SEMI) begin
                  // closing quote-semicolon ends the value
                  vend_in   = entry.position - 1'b1;
                  vstate_in = VS_DONE;
                  quote_in  = 1'b0;
               end else begin
                  quote_in = (b == CHAR_QUOTE);
                  if (!sep_seen_ff) begin
                     unique case (sep_idx_ff)
                        2'd0: sep_idx_in = (b == CHAR_SPACE) ? 2'd1 : 2'd0;
                        2'd1: sep_idx_in = (b == CHAR_DASH)  ? 2'd2 :
                                           (b == CHAR_SPACE) ? 2'd1 : 2'd0;
                        default: begin
                           if (b == CHAR_SPACE) begin
                              sep_seen_in = 1'b1;
                              sep_pos_in  = entry.position - POS_W'(2) - vstart_ff;
                           end
                           sep_idx_in = 2'd0;
                        end
                     endcase
                  end
               end
            end
            default: ;
         endcase

         if (entry.last) begin
            block_end_in = 1'b1;
            if (vstate_in == VS_DONE) begin
               title_found_in  = 1'b1;
               title_offset_in = vstart_in;
               title_length_in = vend_in - vstart_in;
               if (sep_seen_in) begin
                  split_found_in  = 1'b1;
                  split_offset_in = sep_pos_in;
               end
            end
         end
      end

      // A length byte or the end of a block starts the matchers afresh
      if (take && (entry.byte_class == CLASS_LENGTH ||
                   (entry.byte_class == CLASS_META && entry.last))) begin
         key_idx_in  = '0;
         vstate_in   = VS_KEY;
         quote_in    = 1'b0;
         vstart_in   = '0;
         vend_in     = '0;
         sep_idx_in  = '0;
         sep_seen_in = 1'b0;
         sep_pos_in  = '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_idx_ff   <= '0;
         vstate_ff    <= VS_KEY;
         quote_ff     <= 1'b0;
         vstart_ff    <= '0;
         vend_ff      <= '0;
         sep_idx_ff   <= '0;
         sep_seen_ff  <= 1'b0;
         sep_pos_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_idx_ff  <= key_idx_in;
         vstate_ff   <= vstate_in;
         quote_ff    <= quote_in;
         vstart_ff   <= vstart_in;
         vend_ff     <= vend_in;
         sep_idx_ff  <= sep_idx_in;
         sep_seen_ff <= sep_seen_in;
         sep_pos_ff  <= sep_pos_in;
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload, loaded on each new transfer
   always_ff @(posedge clock) begin
      if (take) begin
         class_ff        <= entry.byte_class;
         value_ff        <= b;
         block_end_ff    <= block_end_in;
         title_found_ff  <= title_found_in;
         title_offset_ff <= title_offset_in;
         title_length_ff <= title_length_in;
         split_found_ff  <= split_found_in;
         split_offset_ff <= split_offset_in;
      end
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.byte_class         = class_ff;
   assign rsp.byte_value         = value_ff;
   assign rsp.block_end          = block_end_ff;
   assign rsp.title_found        = title_found_ff;
   assign rsp.title_offset       = title_offset_ff;
   assign rsp.title_length       = title_length_ff;
   assign rsp.artist_split_found = split_found_ff;
   assign rsp.split_offset       = split_offset_ff;

   // Report fields only ever appear on the last metadata byte
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid_ff && block_end_ff |-> class_ff == CLASS_META)
      else $error("block end on a non-metadata byte");
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid_ff && title_found_ff |-> block_end_ff)
      else $error("title reported away from block end");
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid_ff && split_found_ff |-> title_found_ff)
      else $error("separator reported without a title");

endmodule

@@ hw/rtl/icy_metadata_deframer.sv @@
// Top level of the ICY metadata deframer: framer, queue and parser.
`timescale 1ns / 1ps
//
// The req channel takes one body byte per transfer (kind = 0) or a restart
// command (kind = 1). Each body byte comes out on the rsp channel with its
// class (audio, metadata length or metadata); a restart gives no result.
// On the last byte of a nonempty metadata block the result also carries the
// offset and length of the first StreamTitle value and the offset of the
// first " - " inside it. The interval register must be written through csr_*
// only while the block is idle; the block itself does not enforce this.
// A byte accepted on req is written into the queue and from there into the
// output register. Throughput: one byte per cycle while the receiver keeps
// rsp.ready high, set by the counter update in the framer and the matcher
// update in the parser.
// Reset clears the interval to zero (every byte audio), the framing
// counters, the matchers, the queue and the valid flag of the output register.
// When the receiver stalls, the output register holds its result and the
// four-entry queue fills; req.ready drops once the queue is full.
//
module icy_metadata_deframer import icy_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [INTERVAL_W-1:0] csr_write_data,
   icy_req_if.sink               req,
   icy_rsp_if.source             rsp
);

   logic          push;
   logic          pop;
   logic          queue_full;
   logic          queue_empty;
   icy_entry_type push_entry;
   icy_entry_type pop_entry;

   // Front: classification and framing
   icy_framer u_framer (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req),
      .queue_full       (queue_full),
      .push             (push),
      .entry            (push_entry)
   );

   // Decoupling queue
   icy_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .empty      (queue_empty),
      .pop_entry  (pop_entry)
   );

   // Back: title parsing and result output
   icy_parser u_parser (
      .clock (clock),
      .reset (reset),
      .empty (queue_empty),
      .entry (pop_entry),
      .pop   (pop),
      .rsp   (rsp)
   );

endmodule

@@ tb/tb.sv @@
// Testbench for the ICY metadata deframer: directed and random body streams against a byte model.
`timescale 1ns / 1ps

module tb;
   import icy_pkg::*;

   localparam int STUCK_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_CYCLES   = 150;
   localparam int RANDOM_ITEMS  = 760;
   localparam int STAGE_ITEMS   = 180;

   localparam logic KIND_BYTE    = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   localparam logic [8*KEY_LEN-1:0] TITLE_TAG = "StreamTitle='";

   // One classified byte as it should leave the block
   typedef struct packed {
      logic [1:0]       cls;
      logic [7:0]       value;
      logic             blk_end;
      logic             title_hit;
      logic [POS_W-1:0] title_off;
      logic [POS_W-1:0] title_len;
      logic             split_hit;
      logic [POS_W-1:0] split_off;
   } byte_report_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_enable;
   logic [INTERVAL_W-1:0] csr_write_data;

   icy_req_if req_ch ();
   icy_rsp_if rsp_ch ();

   icy_metadata_deframer uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req_ch),
      .rsp              (rsp_ch)
   );

   // Model state
   logic [INTERVAL_W-1:0] interval_reg;
   logic [INTERVAL_W-1:0] audio_count;
   phase_type             frame_phase;
   logic [POS_W-1:0]      meta_count;
   logic [POS_W-1:0]      block_pos;
   logic [KEY_IDX_W-1:0]  key_pos;
   value_state_type       title_state;
   logic                  quote_seen;
   logic [POS_W-1:0]      value_first;
   logic [POS_W-1:0]      value_last;
   logic [1:0]            split_step;
   logic                  split_seen;
   logic [POS_W-1:0]      split_pos;

   byte_report_type reports_due [$];
   logic [7:0]      meta_text [$];

   int unsigned errors = 0;
   int unsigned items_sent = 0;
   int unsigned restarts_sent = 0;
   int unsigned results_checked = 0;
   int unsigned blocks_seen = 0;
   int unsigned titles_seen = 0;
   int unsigned splits_seen = 0;
   int unsigned stuck_cycles = 0;
   int unsigned holds_asked = 0;
   int unsigned holds_given = 0;
   int unsigned hold_left = 0;
   bit          steady = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Byte model
   // ---------------------------------------------------------------

   function automatic logic [7:0] key_char(int idx);
      return TITLE_TAG[8*(KEY_LEN-1-idx) +: 8];
   endfunction

   function void clear_title_search();
      block_pos   = '0;
      key_pos     = '0;
      title_state = VS_KEY;
      quote_seen  = 1'b0;
      value_first = '0;
      value_last  = '0;
      split_step  = '0;
      split_seen  = 1'b0;
      split_pos   = '0;
   endfunction

   function void reset_deframer_model();
      interval_reg = '0;
      audio_count  = '0;
      frame_phase  = PHASE_AUDIO;
      meta_count   = '0;
      clear_title_search();
   endfunction

   // " - " search over bytes that may belong to the value
   function void track_separator(logic [7:0] b, logic [POS_W-1:0] pos);
      if (!split_seen) begin
         case (split_step)
            2'd0: split_step = (b == CHAR_SPACE) ? 2'd1 : 2'd0;
            2'd1: split_step = (b == CHAR_DASH) ? 2'd2 : ((b == CHAR_SPACE) ? 2'd1 : 2'd0);
            default: begin
               if (b == CHAR_SPACE) begin
                  split_seen = 1'b1;
                  split_pos  = pos - 12'd2 - value_first;
               end
               split_step = 2'd0;
            end
         endcase
      end
   endfunction

   // Key match, then the value up to the first quote-semicolon
   function automatic void track_title(logic [7:0] b, logic [POS_W-1:0] pos);
      logic [KEY_IDX_W-1:0] k;
      k = key_pos;
      case (title_state)
         VS_KEY: begin
            if (k >= KEY_LEN) k = '0;
            if (b == key_char(int'(k))) k = k + 1'b1;
            else k = (b == key_char(0)) ? KEY_IDX_W'(1) : '0;
            if (k == KEY_LEN) begin
               key_pos     = '0;
               title_state = VS_VALUE;
               value_first = pos + 1'b1;
               quote_seen  = 1'b0;
               split_step  = '0;
               split_seen  = 1'b0;
            end else begin
               key_pos = k;
            end
         end
         VS_VALUE: begin
            if (quote_seen && b == CHAR_SEMI) begin
               value_last  = pos - 1'b1;
               title_state = VS_DONE;
               quote_seen  = 1'b0;
            end else begin
               quote_seen = (b == CHAR_QUOTE);
               track_separator(b, pos);
            end
         end
         default: ;
      endcase
   endfunction

   // Advance the model by one accepted transfer and queue its report
   function automatic void deframe_byte(logic kind, logic [7:0] b);
      byte_report_type rep;
      if (kind == KIND_RESTART) begin
         frame_phase = PHASE_AUDIO;
         audio_count = interval_reg;
         meta_count  = '0;
         clear_title_search();
         return;
      end
      rep       = '0;
      rep.value = b;
      if (frame_phase == PHASE_AUDIO && interval_reg != 0 && audio_count == 0)
         frame_phase = PHASE_LENGTH;
      case (frame_phase)
         PHASE_AUDIO: begin
            rep.cls = CLASS_AUDIO;
            if (interval_reg != 0) begin
               audio_count = audio_count - 1'b1;
               if (audio_count == 0) frame_phase = PHASE_LENGTH;
            end
         end
         PHASE_LENGTH: begin
            rep.cls    = CLASS_LENGTH;
            meta_count = {b, 4'b0000};
            clear_title_search();
            if (meta_count == 0) begin
               frame_phase = PHASE_AUDIO;
               audio_count = interval_reg;
            end else begin
               frame_phase = PHASE_META;
            end
         end
         default: begin
            rep.cls = CLASS_META;
            track_title(b, block_pos);
            block_pos  = block_pos + 1'b1;
            meta_count = meta_count - 1'b1;
            if (meta_count == 0) begin
               rep.blk_end = 1'b1;
               blocks_seen++;
               if (title_state == VS_DONE) begin
                  rep.title_hit = 1'b1;
                  rep.title_off = value_first;
                  rep.title_len = value_last - value_first;
                  titles_seen++;
                  if (split_seen) begin
                     rep.split_hit = 1'b1;
                     rep.split_off = split_pos;
                     splits_seen++;
                  end
               end
               clear_title_search();
               frame_phase = PHASE_AUDIO;
               audio_count = interval_reg;
            end
         end
      endcase
      reports_due.push_back(rep);
   endfunction

   // ---------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------

   // Offer one item; valid stays high on return so back-to-back transfers need no gap
   task automatic send_item(logic kind, logic [7:0] b);
      if (!steady) begin
         while ($urandom_range(99) < 6) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_ch.valid     <= 1'b1;
      req_ch.kind      <= kind;
      req_ch.data_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      deframe_byte(kind, b);
      items_sent++;
      if (kind == KIND_RESTART) restarts_sent++;
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (reports_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_interval(logic [INTERVAL_W-1:0] v);
      wait_idle();
      csr_write_data   <= v;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      interval_reg = v;
   endtask

   function void add_text(string s);
      for (int i = 0; i < s.len(); i++) meta_text.push_back(s[i]);
   endfunction

   // Title text with spaces, dashes, stray quotes and semicolons, often an artist split
   function automatic void add_random_title();
      int n;
      int split_at;
      n        = $urandom_range(0, 16);
      split_at = $urandom_range(0, 1) ? int'($urandom_range(0, n)) : -1;
      for (int i = 0; i <= n; i++) begin
         if (i == split_at) add_text(" - ");
         if (i < n) begin
            case ($urandom_range(0, 11))
               0: meta_text.push_back(CHAR_SPACE);
               1: meta_text.push_back(CHAR_DASH);
               2: meta_text.push_back(CHAR_QUOTE);
               3: meta_text.push_back(CHAR_SEMI);
               4: meta_text.push_back(8'($urandom_range(128, 255)));
               default: meta_text.push_back(8'h61 + 8'($urandom_range(0, 25)));
            endcase
         end
      end
   endfunction

   // Metadata text: mostly well-formed, some broken, some noise
   function automatic void build_metadata(int unsigned size);
      meta_text.delete();
      case ($urandom_range(0, 9))
         7: repeat (size) meta_text.push_back(8'($urandom_range(0, 255)));
         8: begin
            // key close to the end, value often cut off
            repeat ((size > 20) ? size - 20 : 0) meta_text.push_back(8'h00);
            add_text("StreamTitle='");
            add_random_title();
            add_text("';");
         end
         9: begin
            // only the first title counts
            add_text("StreamTitle='");
            add_random_title();
            add_text("';StreamTitle='");
            add_random_title();
            add_text("';");
         end
         default: begin
            case ($urandom_range(0, 3))
               1: add_text("StreamTi");
               2: add_text("S");
               3: add_text("StreamTitle=");
               default: ;
            endcase
            add_text("StreamTitle='");
            add_random_title();
            case ($urandom_range(0, 5))
               0: ;
               1: add_text("' ;");
               default: add_text("';");
            endcase
            if ($urandom_range(0, 1)) add_text("StreamUrl='';");
         end
      endcase
      while (meta_text.size() < size)
         meta_text.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h00);
   endfunction

   function automatic logic [7:0] pick_length();
      case ($urandom_range(0, 19))
         0, 1:       return 8'd0;
         2, 3, 4, 5: return 8'd1;
         18, 19:     return 8'($urandom_range(4, 6));
         default:    return 8'($urandom_range(2, 3));
      endcase
   endfunction

   // Audio run, length byte, then the block from meta_text (zero padded)
   task automatic send_frame(int unsigned n_audio, logic [7:0] len, bit may_break);
      for (int unsigned i = 0; i < n_audio; i++)
         send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
      send_item(KIND_BYTE, len);
      for (int unsigned i = 0; i < len * 16; i++) begin
         if (may_break && $urandom_range(0, 299) == 0) begin
            send_item(KIND_RESTART, 8'($urandom_range(0, 255)));
            return;
         end
         send_item(KIND_BYTE, (i < meta_text.size()) ? meta_text[i] : 8'h00);
      end
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Interval set after reset with the audio count still zero: next byte is a length byte
   task automatic test_first_length_byte();
      write_interval(2);
      send_item(KIND_BYTE, 8'h00);
      send_item(KIND_BYTE, 8'hFF);
      send_item(KIND_BYTE, 8'h80);
      send_item(KIND_BYTE, 8'h00);
      send_item(KIND_BYTE, 8'h7F);
   endtask

   // Zero interval: everything is audio and nothing counts down
   task automatic test_unframed_bytes();
      write_interval(0);
      send_item(KIND_BYTE, 8'h00);
      send_item(KIND_BYTE, 8'hFF);
      send_item(KIND_RESTART, 8'hFF);
      send_item(KIND_BYTE, 8'h55);
      send_item(KIND_BYTE, 8'hAA);
   endtask

   task automatic test_max_interval();
      write_interval({INTERVAL_W{1'b1}});
      send_item(KIND_RESTART, 8'h00);
      send_item(KIND_BYTE, 8'h00);
      send_item(KIND_BYTE, 8'hFF);
      send_item(KIND_BYTE, 8'h3C);
   endtask

   // Shortest block that holds a whole title, terminator on the last byte
   task automatic test_short_title();
      write_interval(3);
      send_item(KIND_RESTART, 8'h00);
      meta_text.delete();
      add_text("StreamTitle='a';");
      send_frame(3, 1, 1'b0);
      send_item(KIND_BYTE, 8'h11);
   endtask

   // Restart partway through a block drops the block and reloads the audio count
   task automatic test_restart_in_block();
      meta_text.delete();
      add_text("StreamTitle='x");
      send_item(KIND_RESTART, 8'h00);
      repeat (3) send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
      send_item(KIND_BYTE, 8'd1);
      for (int i = 0; i < 5; i++) send_item(KIND_BYTE, meta_text[i]);
      send_item(KIND_RESTART, 8'hA5);
      repeat (3) send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
      send_item(KIND_BYTE, 8'd0);
      send_item(KIND_BYTE, 8'h42);
   endtask

   // A block that has begun finishes unchanged after the interval is rewritten
   task automatic test_interval_change_in_block();
      write_interval(4);
      meta_text.delete();
      add_text("StreamTitle='b';");
      send_item(KIND_RESTART, 8'h00);
      repeat (4) send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
      send_item(KIND_BYTE, 8'd1);
      for (int i = 0; i < 4; i++) send_item(KIND_BYTE, meta_text[i]);
      write_interval(1);
      for (int i = 4; i < 16; i++) send_item(KIND_BYTE, meta_text[i]);
      send_item(KIND_BYTE, 8'hE7);
      send_item(KIND_BYTE, 8'd0);
      send_item(KIND_BYTE, 8'h18);
   endtask

   // Random streams, framed and unframed, over several intervals, with a receiver hold-off and a gap-free stage
   task automatic test_random_stream();
      int unsigned first_item;
      int unsigned next_switch;
      int unsigned stage;
      logic [7:0]  len;
      first_item  = items_sent;
      next_switch = 0;
      stage       = 0;
      while (items_sent - first_item < RANDOM_ITEMS) begin
         if (items_sent - first_item >= next_switch) begin
            case (stage)
               0:       write_interval(1);
               1:       write_interval(INTERVAL_W'($urandom_range(2, 8)));
               2:       write_interval(0);
               default: write_interval(INTERVAL_W'($urandom_range(1, 12)));
            endcase
            steady = (stage == 3);
            if (stage == 1) holds_asked++;
            send_item(KIND_RESTART, 8'($urandom_range(0, 255)));
            stage++;
            next_switch += STAGE_ITEMS;
         end
         if (interval_reg == 0) begin
            repeat (20) send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
         end else begin
            len = pick_length();
            build_metadata(len * 16);
            send_frame(32'(interval_reg), len, 1'b1);
         end
      end
      steady = 1'b0;
   endtask

   // Long block, title near its end so the offsets run well past the first hundred bytes
   task automatic test_long_block();
      write_interval(1);
      send_item(KIND_RESTART, 8'h00);
      meta_text.delete();
      repeat (220) meta_text.push_back(8'h00);
      add_text("StreamTitle='Artist - Song';");
      send_frame(1, 8'd16, 1'b0);
      send_item(KIND_BYTE, 8'h99);
   endtask

   // ---------------------------------------------------------------
   // Receiver, checker and watchdog
   // ---------------------------------------------------------------

   // Random stalls, one long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (holds_asked != holds_given) begin
         holds_given  <= holds_asked;
         hold_left    <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= steady || ($urandom_range(99) >= 6);
      end
   end

   function void check_field(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   // Each result transfer against the oldest expectation
   always @(posedge clock) begin
      byte_report_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (reports_due.size() == 0) begin
            $display("%0t: unexpected result, class %0d byte %0h block_end %0b", $time,
                     rsp_ch.byte_class, rsp_ch.byte_value, rsp_ch.block_end);
            errors++;
         end else begin
            want = reports_due.pop_front();
            check_field("byte_class", POS_W'(want.cls), POS_W'(rsp_ch.byte_class));
            check_field("byte_value", POS_W'(want.value), POS_W'(rsp_ch.byte_value));
            check_field("block_end", POS_W'(want.blk_end), POS_W'(rsp_ch.block_end));
            check_field("title_found", POS_W'(want.title_hit), POS_W'(rsp_ch.title_found));
            check_field("title_offset", want.title_off, rsp_ch.title_offset);
            check_field("title_length", want.title_len, rsp_ch.title_length);
            check_field("artist_split_found", POS_W'(want.split_hit),
                        POS_W'(rsp_ch.artist_split_found));
            check_field("split_offset", want.split_off, rsp_ch.split_offset);
            results_checked++;
         end
      end
   end

   // Ends the run if no transfer happens on either side for too long
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
                     stuck_cycles, reports_due.size());
            $display("FAIL icy_metadata_deframer");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------

   initial begin
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      req_ch.valid     <= 1'b0;
      req_ch.kind      <= KIND_BYTE;
      req_ch.data_byte <= 8'h00;
      reset_deframer_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_first_length_byte();
      test_unframed_bytes();
      test_max_interval();
      test_short_title();
      test_restart_in_block();
      test_interval_change_in_block();
      test_random_stream();
      test_long_block();
      wait_idle();

      $display("Sent %0d transfers (%0d restarts), checked %0d results", items_sent,
               restarts_sent, results_checked);
      $display("Metadata blocks %0d, with title %0d, with artist split %0d", blocks_seen,
               titles_seen, splits_seen);
      if (errors == 0) begin
         $display("PASS icy_metadata_deframer");
      end else begin
         $display("%0d mismatches", errors);
         $display("FAIL icy_metadata_deframer");
      end
      $finish;
   end

endmodule
